// ===== sv/pcxd_pkg.sv =====
package pcxd_pkg;

  localparam int PALETTE_DEPTH_DEF = 256;
  localparam int COORD_BITS_DEF    = 16;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic [CFG_INDEX_BITS-1:0] REG_RAW_MODE     = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd2;

  localparam logic [15:0] IMAGE_WIDTH_RST  = 16'd320;
  localparam logic [15:0] IMAGE_HEIGHT_RST = 16'd200;

  localparam logic [1:0] FUNC_PALETTE = 2'd0;
  localparam logic [1:0] FUNC_DATA    = 2'd1;
  localparam logic [1:0] FUNC_START   = 2'd2;

  localparam logic [7:0] RUN_MARK = 8'd192;
  localparam int RUN_BITS = 6;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] data_byte;
    logic [7:0] palette_index;
    logic [7:0] pal_red;
    logic [7:0] pal_green;
    logic [7:0] pal_blue;
  } in_item_t;

  typedef struct packed {
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        last_of_run;
    logic        image_done;
  } out_item_t;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic run_start;
    logic run_end;
    logic out_free;
  } sts_t;

endpackage

// ===== sv/pcxd_ctrl.sv =====
module pcxd_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  pcxd_pkg::sts_t sts,
  output pcxd_pkg::cmd_t cmd
);

  pcxd_pkg::state_t state;
  pcxd_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pcxd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    cmd        = '0;
    case (state)
      pcxd_pkg::ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
        if (in_valid && sts.run_start) begin
          state_next = pcxd_pkg::ST_EMIT;
        end
      end
      pcxd_pkg::ST_EMIT: begin
        cmd.load = sts.out_free;
        if (sts.out_free && sts.run_end) begin
          state_next = pcxd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pcxd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/pcxd_dpath.sv =====
module pcxd_dpath #(
  parameter int PALETTE_DEPTH = pcxd_pkg::PALETTE_DEPTH_DEF,
  parameter int COORD_BITS    = pcxd_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  pcxd_pkg::cmd_t                      cmd,
  output pcxd_pkg::sts_t                      sts,
  input  pcxd_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output pcxd_pkg::out_item_t                 out_data,
  input  logic                                cfg_write,
  input  logic [pcxd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [pcxd_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int AW = $clog2(PALETTE_DEPTH);
  localparam int RB = pcxd_pkg::RUN_BITS;

  logic        raw_mode;
  logic [15:0] image_width;
  logic [15:0] image_height;

  logic [23:0]             mem [PALETTE_DEPTH];
  logic [PALETTE_DEPTH-1:0] pal_valid;
  logic [23:0]             rd_data;
  logic                    rd_hit;
  logic [23:0]             rgb;

  logic [COORD_BITS-1:0] column;
  logic [COORD_BITS-1:0] row;
  logic                  awaiting_colour;
  logic [RB-1:0]         pending_run;
  logic                  frame_complete;
  logic [RB-1:0]         cnt;

  logic                  is_data;
  logic                  wr_in_range;
  logic                  rd_in_range;
  logic [RB-1:0]         run_count;
  logic [COORD_BITS:0]   col_inc;
  logic [COORD_BITS:0]   row_inc;
  logic                  col_wrap;
  logic                  row_wrap;
  logic                  completes;

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_mode     <= 1'b0;
      image_width  <= pcxd_pkg::IMAGE_WIDTH_RST;
      image_height <= pcxd_pkg::IMAGE_HEIGHT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        pcxd_pkg::REG_RAW_MODE:     raw_mode     <= cfg_data[0];
        pcxd_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        pcxd_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign is_data     = in_data.func == pcxd_pkg::FUNC_DATA;
  assign wr_in_range = {1'b0, in_data.palette_index} < 9'(PALETTE_DEPTH);
  assign rd_in_range = {1'b0, in_data.data_byte} < 9'(PALETTE_DEPTH);

  always_comb begin
    run_count = '0;
    if (is_data && !frame_complete) begin
      if (raw_mode) begin
        run_count = RB'(1);
      end else if (awaiting_colour) begin
        run_count = pending_run;
      end else if (in_data.data_byte >= pcxd_pkg::RUN_MARK) begin
        run_count = '0;
      end else begin
        run_count = RB'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && in_data.func == pcxd_pkg::FUNC_PALETTE && wr_in_range) begin
      mem[in_data.palette_index[AW-1:0]] <= {in_data.pal_red, in_data.pal_green,
                                             in_data.pal_blue};
    end
    if (cmd.accept && is_data) begin
      rd_data <= mem[in_data.data_byte[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pal_valid <= '0;
      rd_hit    <= 1'b0;
    end else if (cmd.accept) begin
      if (in_data.func == pcxd_pkg::FUNC_PALETTE && wr_in_range) begin
        pal_valid[in_data.palette_index[AW-1:0]] <= 1'b1;
      end
      if (is_data) begin
        rd_hit <= rd_in_range && pal_valid[in_data.data_byte[AW-1:0]];
      end
    end
  end

  assign rgb = rd_hit ? rd_data : 24'd0;

  assign col_inc   = {1'b0, column} + 1'b1;
  assign row_inc   = {1'b0, row} + 1'b1;
  assign col_wrap  = (17'(col_inc) >= 17'(image_width)) || (&column);
  assign row_wrap  = (17'(row_inc) >= 17'(image_height)) || (&row);
  assign completes = col_wrap && row_wrap;

  assign sts.run_start = run_count != '0;
  assign sts.run_end   = (cnt == RB'(1)) || completes;
  assign sts.out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      column          <= '0;
      row             <= '0;
      awaiting_colour <= 1'b0;
      pending_run     <= '0;
      frame_complete  <= 1'b0;
      cnt             <= '0;
    end else if (cmd.accept) begin
      if (in_data.func == pcxd_pkg::FUNC_START) begin
        column          <= '0;
        row             <= '0;
        awaiting_colour <= 1'b0;
        pending_run     <= '0;
        frame_complete  <= 1'b0;
      end else if (is_data && !frame_complete) begin
        cnt <= run_count;
        if (raw_mode || awaiting_colour) begin
          awaiting_colour <= 1'b0;
          pending_run     <= '0;
        end else if (in_data.data_byte >= pcxd_pkg::RUN_MARK) begin
          awaiting_colour <= 1'b1;
          pending_run     <= in_data.data_byte[RB-1:0];
        end
      end
    end else if (cmd.load) begin
      cnt <= cnt - 1'b1;
      if (col_wrap) begin
        column <= '0;
        if (row_wrap) begin
          frame_complete <= 1'b1;
        end else begin
          row <= row_inc[COORD_BITS-1:0];
        end
      end else begin
        column <= col_inc[COORD_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_data.pixel_x     <= 16'(column);
      out_data.pixel_y     <= 16'(row);
      out_data.red         <= rgb[23:16];
      out_data.green       <= rgb[15:8];
      out_data.blue        <= rgb[7:0];
      out_data.last_of_run <= sts.run_end;
      out_data.image_done  <= completes;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_pixel_after_frame: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !frame_complete)
    else $error("pixel loaded after frame completed");

  a_run_count_live: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> cnt != '0)
    else $error("pixel loaded with empty run counter");

  a_frame_marks: assert property (@(posedge clk) disable iff (rst)
    (cmd.load && completes) |=> (frame_complete && out_valid && out_data.image_done))
    else $error("image completion not recorded");

  a_load_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (!out_valid || !out_stall))
    else $error("output register overwritten while stalled");
`endif

endmodule

// ===== sv/pcx_rle_palette_decoder.sv =====
// PCX 8-bit decoder: turns a run-length coded (or raw) byte stream into RGB pixels with
// x/y positions through a palette that palette items load. Palette, start and run-marker
// bytes, and bytes that emit nothing, are accepted without a stall; a data byte that emits
// n pixels is first accepted, which starts the registered palette read, and its pixels then
// follow one per cycle while the output is not stalled, set by the single output register.
// Input is stalled while a run is being emitted; the next item is accepted while the final
// pixel of a run still waits in the output register.
module pcx_rle_palette_decoder #(
  parameter int PALETTE_DEPTH = pcxd_pkg::PALETTE_DEPTH_DEF,
  parameter int COORD_BITS    = pcxd_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  pcxd_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output pcxd_pkg::out_item_t                 out_data,
  input  logic                                cfg_write,
  input  logic [pcxd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [pcxd_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  pcxd_pkg::cmd_t cmd;
  pcxd_pkg::sts_t sts;

  pcxd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  pcxd_dpath #(
    .PALETTE_DEPTH (PALETTE_DEPTH),
    .COORD_BITS    (COORD_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule
